/* design/dtfp_pkg.sv */
// shared types and constants for the decimal text to fixed point core
// used by the controller, the datapath and the port checker
package dtfp_pkg;

	// controller states: the parse phases, then divide and emit
	typedef enum logic [2:0] {
		S_START,
		S_SIGNED,
		S_WHOLE,
		S_FRAC,
		S_ERROR,
		S_DIVIDE,
		S_EMIT
	} state_t;

	typedef logic [1:0] status_code_t;

	localparam status_code_t ST_OK        = 2'd0;
	localparam status_code_t ST_MALFORMED = 2'd1;
	localparam status_code_t ST_OVERFLOW  = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clear;
		logic set_neg;
		logic acc_whole;
		logic acc_frac;
		logic mark_bad;
		logic div_init;
		logic div_step;
		logic load_out;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_digit;
		logic is_minus;
		logic is_plus;
		logic is_point;
		logic is_term;
		logic div_last;
		logic out_free;
	} stat_t;

	// elaboration-time power of ten, sizes the fraction registers
	function automatic logic [63:0] pow10(input int n);
		logic [63:0] p;
		p = 64'd1;
		for (int i = 0; i < n; i++) begin
			p = p * 64'd10;
		end
		return p;
	endfunction

endpackage

/* design/dtfp_ctrl.sv */
// controller state machine: parse phases, divide sequencing, result hand-off
// depends on dtfp_pkg for the state type and the command and status structs
module dtfp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_stall,
	input  dtfp_pkg::stat_t   stat,
	output dtfp_pkg::cmd_t    cmd
);

	dtfp_pkg::state_t state_q;
	dtfp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtfp_pkg::S_START;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		logic take;
		take       = 1'b0;
		state_d    = state_q;
		cmd        = '0;
		char_stall = 1'b1;
		case (state_q)
			dtfp_pkg::S_START, dtfp_pkg::S_SIGNED, dtfp_pkg::S_WHOLE,
			dtfp_pkg::S_FRAC, dtfp_pkg::S_ERROR: begin
				char_stall = 1'b0;
				take       = char_valid;
			end
			dtfp_pkg::S_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = dtfp_pkg::S_EMIT;
				end
			end
			dtfp_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					cmd.clear    = 1'b1;
					state_d      = dtfp_pkg::S_START;
				end
			end
			default: begin
				state_d = dtfp_pkg::S_START;
			end
		endcase

		if (take) begin
			if (stat.is_term) begin
				if (state_q == dtfp_pkg::S_WHOLE || state_q == dtfp_pkg::S_FRAC) begin
					cmd.div_init = 1'b1;
					state_d      = dtfp_pkg::S_DIVIDE;
				end else begin
					cmd.mark_bad = 1'b1;
					state_d      = dtfp_pkg::S_EMIT;
				end
			end else begin
				case (state_q)
					dtfp_pkg::S_START: begin
						if (stat.is_minus) begin
							cmd.set_neg = 1'b1;
							state_d     = dtfp_pkg::S_SIGNED;
						end else if (stat.is_plus) begin
							state_d = dtfp_pkg::S_SIGNED;
						end else if (stat.is_digit) begin
							cmd.acc_whole = 1'b1;
							state_d       = dtfp_pkg::S_WHOLE;
						end else begin
							state_d = dtfp_pkg::S_ERROR;
						end
					end
					dtfp_pkg::S_SIGNED: begin
						if (stat.is_digit) begin
							cmd.acc_whole = 1'b1;
							state_d       = dtfp_pkg::S_WHOLE;
						end else begin
							state_d = dtfp_pkg::S_ERROR;
						end
					end
					dtfp_pkg::S_WHOLE: begin
						if (stat.is_digit) begin
							cmd.acc_whole = 1'b1;
						end else if (stat.is_point) begin
							state_d = dtfp_pkg::S_FRAC;
						end else begin
							state_d = dtfp_pkg::S_ERROR;
						end
					end
					dtfp_pkg::S_FRAC: begin
						if (stat.is_digit) begin
							cmd.acc_frac = 1'b1;
						end else begin
							state_d = dtfp_pkg::S_ERROR;
						end
					end
					default: begin
						state_d = dtfp_pkg::S_ERROR;
					end
				endcase
			end
		end
	end

endmodule

/* design/dtfp_datapath.sv */
// datapath: character classes, digit accumulators, restoring divider, result register
// depends on dtfp_pkg for the command and status structs and the character codes
module dtfp_datapath #(
	parameter int INT_BITS        = 16,
	parameter int FRAC_BITS       = 16,
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            char_code,
	input  dtfp_pkg::cmd_t        cmd,
	output dtfp_pkg::stat_t       stat,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [31:0]    value,
	output logic [1:0]            status
);

	localparam int WH_W  = INT_BITS - 1;
	localparam int DEN_W = $clog2(dtfp_pkg::pow10(MAX_FRAC_DIGITS) + 64'd1);
	localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int BIT_W = $clog2(FRAC_BITS);
	localparam int MAG_W = WH_W + FRAC_BITS;
	localparam int EXT_W = (MAG_W > 32) ? MAG_W : 32;

	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAC_DIGITS);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(FRAC_BITS - 1);

	logic                  neg_q;
	logic                  bad_q;
	logic                  ovf_q;
	logic [WH_W-1:0]       whole_q;
	logic [DEN_W-1:0]      fd_q;
	logic [DEN_W-1:0]      den_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DEN_W-1:0]      rem_q;
	logic [FRAC_BITS-1:0]  quo_q;
	logic [BIT_W-1:0]      bit_q;
	logic                  result_valid_q;
	logic signed [31:0]    value_q;
	logic [1:0]            status_q;

	logic [3:0]            digit;
	logic [WH_W+3:0]       whole_wide;
	logic [DEN_W-1:0]      fd_next;
	logic [DEN_W-1:0]      den_next;
	logic [DEN_W:0]        rem_sh;
	logic                  rem_ge;
	logic [MAG_W-1:0]      mag;
	logic [EXT_W-1:0]      mag_ext;
	logic [31:0]           mag_lo;
	logic signed [31:0]    value_d;
	logic [1:0]            status_d;

	// character classes
	always_comb begin
		stat          = '0;
		stat.is_digit = char_code inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]};
		stat.is_minus = (char_code == dtfp_pkg::CH_MINUS);
		stat.is_plus  = (char_code == dtfp_pkg::CH_PLUS);
		stat.is_point = (char_code == dtfp_pkg::CH_POINT);
		stat.is_term  = char_code inside {dtfp_pkg::CH_NUL, dtfp_pkg::CH_LF};
		stat.div_last = (bit_q == BIT_LAST);
		stat.out_free = !result_valid_q || !result_stall;
	end

	// ascii digits carry their value in the low nibble
	assign digit = char_code[3:0];

	// times ten as shift-and-add
	assign whole_wide = {1'b0, whole_q, 3'b000} + {3'b000, whole_q, 1'b0}
		+ (WH_W+4)'(digit);
	assign fd_next  = DEN_W'({fd_q, 3'b000}) + DEN_W'({fd_q, 1'b0}) + DEN_W'(digit);
	assign den_next = DEN_W'({den_q, 3'b000}) + DEN_W'({den_q, 1'b0});

	// one quotient bit per cycle
	assign rem_sh = {rem_q, 1'b0};
	assign rem_ge = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neg_q   <= 1'b0;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
			whole_q <= '0;
			fd_q    <= '0;
			den_q   <= DEN_W'(1);
			cnt_q   <= '0;
			bit_q   <= '0;
		end else if (cmd.clear) begin
			neg_q   <= 1'b0;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
			whole_q <= '0;
			fd_q    <= '0;
			den_q   <= DEN_W'(1);
			cnt_q   <= '0;
			bit_q   <= '0;
		end else begin
			if (cmd.set_neg) begin
				neg_q <= 1'b1;
			end
			if (cmd.mark_bad) begin
				bad_q <= 1'b1;
			end
			if (cmd.acc_whole) begin
				if (whole_wide[WH_W+3:WH_W] != 4'd0) begin
					whole_q <= '1;
					ovf_q   <= 1'b1;
				end else begin
					whole_q <= whole_wide[WH_W-1:0];
				end
			end
			// digits past the limit are dropped
			if (cmd.acc_frac && cnt_q < CNT_MAX) begin
				fd_q  <= fd_next;
				den_q <= den_next;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.div_init) begin
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + BIT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q <= fd_q;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_q << 1;
			quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
		end
	end

	// saturated magnitude is all ones, which the saturated whole part already starts
	assign mag     = ovf_q ? '1 : {whole_q, quo_q};
	assign mag_ext = EXT_W'(mag);
	assign mag_lo  = mag_ext[31:0];

	always_comb begin
		if (bad_q) begin
			value_d  = '0;
			status_d = dtfp_pkg::ST_MALFORMED;
		end else begin
			value_d  = neg_q ? -$signed(mag_lo) : $signed(mag_lo);
			status_d = ovf_q ? dtfp_pkg::ST_OVERFLOW : dtfp_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q  <= value_d;
			status_q <= status_d;
		end
	end

	assign result_valid = result_valid_q;
	assign value        = value_q;
	assign status       = status_q;

endmodule

/* design/decimal_text_to_fixed_point_core.sv */
// Decimal text to signed fixed point converter. Characters arrive one per item and are taken
// one per cycle unless the input stalls; a number is an optional sign, one or more digits,
// and an optional point with zero or more fraction digits, ended by NUL or newline. Each
// terminator yields one result: the value in signed fixed point with INT_BITS integer bits
// and FRAC_BITS fraction bits, truncated toward zero, in the low 32 bits of value, with status
// ok, malformed (value zero) or saturated. After a terminator of a well-formed number the
// input stalls while a restoring divider produces the fraction one quotient bit per cycle,
// then while the result is loaded; a malformed number stalls it only for that load. Either
// wait grows while a previous result is still held by the output side.
// depends on dtfp_pkg, dtfp_ctrl and dtfp_datapath
module decimal_text_to_fixed_point_core #(
	parameter int INT_BITS        = 16,
	parameter int FRAC_BITS       = 16,
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         char_code,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] value,
	output logic [1:0]         status
);

	dtfp_pkg::cmd_t  cmd;
	dtfp_pkg::stat_t stat;

	dtfp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	dtfp_datapath #(
		.INT_BITS        (INT_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_code    (char_code),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.status       (status)
	);

endmodule

/* design/dtfp_checker.sv */
// port-level checks for the decimal text to fixed point core, bound to the top level
// depends on dtfp_pkg for the status codes and the character codes
module dtfp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               char_valid,
	input logic               char_stall,
	input logic [7:0]         char_code,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] value,
	input logic [1:0]         status
);

	// a stalled result stays up
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(value) && $stable(status))
		else $error("result changed while stalled");

	// a malformed number carries a zero value
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == dtfp_pkg::ST_MALFORMED |-> value == 32'sd0)
		else $error("malformed result with nonzero value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status == dtfp_pkg::ST_OK || status == dtfp_pkg::ST_MALFORMED
			|| status == dtfp_pkg::ST_OVERFLOW)
		else $error("undefined status code");

	// a taken terminator always stalls the input in the cycle after it is taken
	a_term_stall: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && !char_stall && (char_code == dtfp_pkg::CH_NUL
			|| char_code == dtfp_pkg::CH_LF) |=> char_stall)
		else $error("item taken right after a terminator");

endmodule

bind decimal_text_to_fixed_point_core dtfp_checker u_dtfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.char_valid   (char_valid),
	.char_stall   (char_stall),
	.char_code    (char_code),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.value        (value),
	.status       (status)
);
